@@ rtl/steer_kickout_monitor_assert.svh @@
// Assertion macros for the steering kickout monitor checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef STEER_KICKOUT_MONITOR_ASSERT_SVH
`define STEER_KICKOUT_MONITOR_ASSERT_SVH

// Same-cycle implication, off while reset is held
`define SKM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("steer kickout monitor: same-cycle check failed");

// Next-cycle implication, off while reset is held
`define SKM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("steer kickout monitor: next-cycle check failed");

`endif

@@ rtl/skm_pkg.sv @@
// Shared types and constants for the steering kickout monitor.
// No dependencies; used by the top level and its checker.
package skm_pkg;

    // Port widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 24;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 16;

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_MOTOR_KIND = 3'd0,
        CFG_SENSOR_EN  = 3'd1,
        CFG_PULSE_MAX  = 3'd2,
        CFG_CUR_THRESH = 3'd3,
        CFG_SPIKE_MS   = 3'd4
    } t_cfg_addr;

    typedef enum logic [1:0] {
        MK_PWM    = 2'd0,
        MK_CAN    = 2'd1,
        MK_SERIAL = 2'd2,
        MK_BUS    = 2'd3
    } t_motor_kind;

    typedef enum logic [2:0] {
        RSN_NONE      = 3'd0,
        RSN_ENCODER   = 3'd1,
        RSN_PRESSURE  = 3'd2,
        RSN_CURRENT   = 3'd3,
        RSN_SLIP      = 3'd4,
        RSN_CAN_SLIP  = 3'd5,
        RSN_CAN_ERROR = 3'd6,
        RSN_MOTION    = 3'd7
    } t_reason;

    // Sensor enable bit positions
    localparam int EN_ENC = 0;
    localparam int EN_PRS = 1;
    localparam int EN_CUR = 2;
    localparam int EN_MOT = 3;

    // Reset values of the configuration registers
    localparam t_motor_kind RST_MOTOR_KIND = MK_PWM;
    localparam logic [3:0]  RST_SENSOR_EN  = 4'd0;
    localparam logic [15:0] RST_PULSE_MAX  = 16'd3;
    localparam logic [7:0]  RST_CUR_THRESH = 8'd100;
    localparam logic [15:0] RST_SPIKE_MS   = 16'd1000;

    // Current scaling: code 255 equals 1680 ADC counts (ratio 112/17)
    localparam int CUR_FULL_COUNTS = 1680;
    localparam int CUR_FULL_CODE   = 255;
    localparam logic [14:0] CUR_MUL_112 = 15'd112;
    localparam logic [15:0] RECIP_17    = 16'd61681;   // ceil(2^20/17)
    localparam logic [10:0] RECIP_10    = 11'd1639;    // ceil(2^14/10)
    localparam logic [12:0] RECIP_7     = 13'd4682;    // ceil(2^15/7)
    localparam logic [10:0] RST_CUR_TRIP =
        11'(int'(RST_CUR_THRESH) * CUR_FULL_COUNTS / CUR_FULL_CODE);

    // Status frame header bytes summed into the checksum
    localparam int FRAME_SOURCE = 126;
    localparam int FRAME_PGN    = 8'hFA;
    localparam int FRAME_LEN    = 8;
    localparam logic [7:0] FRAME_BASE = 8'((FRAME_SOURCE + FRAME_PGN + FRAME_LEN) % 256);

    // Input request, last field in the lowest bits
    typedef struct packed {
        logic [1:0]         pad;
        logic [15:0]        motor_current_x32;
        logic               can_slip;
        logic [11:0]        current_sample;
        logic [7:0]         pressure_sample;
        logic               encoder_valid;
        logic signed [31:0] encoder_count;
        logic [31:0]        now_ms;
    } t_in_item;

    // Result, last field in the lowest bits
    typedef struct packed {
        logic       pad;
        logic [7:0] frame_checksum;
        logic [7:0] turn_sensor_value;
        logic       encoder_reset;
        logic       kickout_cleared;
        logic       kickout_started;
        t_reason    kickout_reason;
        logic       kickout_active;
    } t_out_item;

    // Trip level floor(thr * 1680 / 255) as thr * 112 / 17
    function automatic logic [10:0] cur_trip_level(input logic [7:0] thr);
        logic [14:0] scaled;
        logic [30:0] prod;
        scaled = 15'(thr) * CUR_MUL_112;
        prod   = 31'(scaled) * 31'(RECIP_17);
        return prod[30:20];
    endfunction

endpackage

@@ rtl/steer_kickout_monitor.sv @@
// Steering kickout monitor: top level, one pipeline of input and result registers.
// Depends on skm_pkg.
//
// Each request is one poll tick. It is registered, evaluated by one pass of compare and
// constant-scaling logic against the held readings and trip state, and the result is
// registered: an accepted tick goes through the input register and then the result register
// to the master side, and the block takes a new tick every cycle as long as the result
// register can drain. The trip level for the current sensor is scaled when current_threshold
// is written, so ticks may follow a configuration write on the next cycle. Configuration writes
// must only happen while no tick is in flight.
module steer_kickout_monitor (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [skm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [skm_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // now_ms[31:0], encoder_count[63:32], encoder_valid[64], pressure_sample[72:65],
    // current_sample[84:73], can_slip[85], motor_current_x32[101:86], zero fill
    input  logic [skm_pkg::IN_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // kickout_active[0], kickout_reason[3:1], kickout_started[4], kickout_cleared[5],
    // encoder_reset[6], turn_sensor_value[14:7], frame_checksum[22:15], zero fill
    output logic [skm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import skm_pkg::*;

    // Configuration registers
    t_motor_kind r_motor_kind;
    logic [3:0]  r_sensor_en;
    logic [15:0] r_pulse_max;
    logic [7:0]  r_cur_thresh;
    logic [10:0] r_cur_trip;
    logic [15:0] r_spike_ms;

    // Pipeline registers
    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      s1_adv;

    // Trip state
    logic [31:0] r_held_count;
    logic [7:0]  r_held_press;
    logic [11:0] r_held_cur;
    logic        r_tripped;
    t_reason     r_cause;
    logic        r_spike_run;
    logic [31:0] r_spike_start;

    logic [31:0] n_held_count;
    logic [7:0]  n_held_press;
    logic [11:0] n_held_cur;
    logic        n_tripped;
    t_reason     n_cause;
    logic        n_spike_run;
    logic [31:0] n_spike_start;
    t_out_item   n_out_item;

    // Evaluation signals
    logic        ext, en_enc, en_prs, en_cur, en_mot;
    logic [31:0] latched_count;
    logic [31:0] count_mag;
    logic        enc_over, prs_over, cur_high, mot_over;
    logic [21:0] trip_tenth_prod;
    logic [11:0] cur_limit;
    logic [31:0] spike_elapsed;
    logic        tmr_run, tmr_res;
    logic [31:0] tmr_start;
    logic        cur_eval, still, started, cleared;
    t_reason     cause_try;
    logic [16:0] cur_x17;
    logic [25:0] cur_code_prod;
    logic [10:0] cur_code;
    logic [7:0]  cur_tsv;
    logic [7:0]  tsv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motor_kind <= RST_MOTOR_KIND;
            r_sensor_en  <= RST_SENSOR_EN;
            r_pulse_max  <= RST_PULSE_MAX;
            r_cur_thresh <= RST_CUR_THRESH;
            r_cur_trip   <= RST_CUR_TRIP;
            r_spike_ms   <= RST_SPIKE_MS;
        end else if (i_cfg_we) begin
            unique case (t_cfg_addr'(i_cfg_addr))
                CFG_MOTOR_KIND: r_motor_kind <= t_motor_kind'(i_cfg_wdata[1:0]);
                CFG_SENSOR_EN:  r_sensor_en  <= i_cfg_wdata[3:0];
                CFG_PULSE_MAX:  r_pulse_max  <= i_cfg_wdata;
                CFG_CUR_THRESH: begin
                    r_cur_thresh <= i_cfg_wdata[7:0];
                    r_cur_trip   <= cur_trip_level(i_cfg_wdata[7:0]);
                end
                CFG_SPIKE_MS:   r_spike_ms   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: stage 1 moves on when the result register is free or draining
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_item <= t_in_item'(s_axis_tdata);
        end
        if (s1_adv) begin
            r_out_item <= n_out_item;
        end
    end

    // Trip state advances with each evaluated tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count  <= '0;
            r_held_press  <= '0;
            r_held_cur    <= '0;
            r_tripped     <= 1'b0;
            r_cause       <= RSN_NONE;
            r_spike_run   <= 1'b0;
            r_spike_start <= '0;
        end else if (s1_adv) begin
            r_held_count  <= n_held_count;
            r_held_press  <= n_held_press;
            r_held_cur    <= n_held_cur;
            r_tripped     <= n_tripped;
            r_cause       <= n_cause;
            r_spike_run   <= n_spike_run;
            r_spike_start <= n_spike_start;
        end
    end

    // Latch readings and sensor compares
    always_comb begin
        ext    = (r_motor_kind == MK_PWM);
        en_enc = r_sensor_en[EN_ENC];
        en_prs = r_sensor_en[EN_PRS];
        en_cur = r_sensor_en[EN_CUR];
        en_mot = r_sensor_en[EN_MOT];

        latched_count = (ext && r_s1_item.encoder_valid) ?
                        32'(r_s1_item.encoder_count) : r_held_count;
        n_held_press  = (r_motor_kind != MK_CAN) ? r_s1_item.pressure_sample : r_held_press;
        n_held_cur    = (r_motor_kind != MK_CAN) ? r_s1_item.current_sample : r_held_cur;

        count_mag = latched_count[31] ? (32'd0 - latched_count) : latched_count;
        enc_over  = count_mag > 32'(r_pulse_max);
        prs_over  = n_held_press > r_pulse_max[7:0];

        // limit = T + floor(T / 10)
        trip_tenth_prod = 22'(r_cur_trip) * 22'(RECIP_10);
        cur_limit       = 12'(r_cur_trip) + 12'(trip_tenth_prod[21:14]);
        cur_high        = n_held_cur > cur_limit;

        mot_over = (r_motor_kind == MK_CAN) &&
                   (r_s1_item.can_slip || (r_s1_item.motor_current_x32 > 16'(r_cur_thresh)));
    end

    // Current spike timer outcome, applied only when the current test is run
    always_comb begin
        spike_elapsed = r_s1_item.now_ms - r_spike_start;
        tmr_run   = 1'b0;
        tmr_res   = 1'b0;
        tmr_start = r_spike_start;
        if (cur_high) begin
            if (!r_spike_run) begin
                tmr_run   = 1'b1;
                tmr_start = r_s1_item.now_ms;
            end else if (spike_elapsed >= 32'(r_spike_ms)) begin
                tmr_res = 1'b1;
            end else begin
                tmr_run = 1'b1;
            end
        end
    end

    // Trip and clear decision
    always_comb begin
        n_tripped = r_tripped;
        n_cause   = r_cause;
        started   = 1'b0;
        cleared   = 1'b0;
        cur_eval  = 1'b0;
        still     = 1'b0;
        cause_try = RSN_NONE;
        if (!r_tripped) begin
            // Idle: trips in priority order
            priority if (ext && en_enc) begin
                cause_try = enc_over ? RSN_ENCODER : RSN_NONE;
            end else if (ext && en_mot && prs_over) begin
                cause_try = RSN_MOTION;
            end else if (ext && en_prs && !en_mot && prs_over) begin
                cause_try = RSN_PRESSURE;
            end else if (ext && en_cur) begin
                cur_eval  = 1'b1;
                cause_try = tmr_res ? RSN_CURRENT : RSN_NONE;
            end else if (mot_over) begin
                cause_try = RSN_CAN_SLIP;
            end else begin
                cause_try = RSN_NONE;
            end
            if (cause_try != RSN_NONE) begin
                n_tripped = 1'b1;
                n_cause   = cause_try;
                started   = 1'b1;
            end
        end else begin
            // Active: retest the cause that tripped
            unique case (r_cause)
                RSN_ENCODER:  still = ext && en_enc && enc_over;
                RSN_PRESSURE: still = ext && en_prs && !en_mot && prs_over;
                RSN_CURRENT: begin
                    cur_eval = ext && en_cur;
                    still    = cur_eval && tmr_res;
                end
                RSN_SLIP, RSN_CAN_SLIP, RSN_CAN_ERROR: still = mot_over;
                default: still = 1'b0;
            endcase
            if (!still) begin
                n_tripped = 1'b0;
                n_cause   = RSN_NONE;
                cleared   = 1'b1;
            end
        end

        n_spike_run   = cur_eval ? tmr_run : r_spike_run;
        n_spike_start = cur_eval ? tmr_start : r_spike_start;
        if (cleared) begin
            n_spike_run = 1'b0;
        end
        n_held_count = cleared ? 32'd0 : latched_count;
    end

    // Turn sensor byte and status frame from the state after the tick
    always_comb begin
        // held_current * 255 / 1680 as ((held * 17) >> 4) / 7
        cur_x17       = 17'(n_held_cur) * 17'd17;
        cur_code_prod = 26'(cur_x17[16:4]) * 26'(RECIP_7);
        cur_code      = cur_code_prod[25:15];
        cur_tsv       = (cur_code > 11'd255) ? 8'hFF : cur_code[7:0];

        if (en_enc) begin
            tsv = (!n_held_count[31] && (n_held_count > 32'd255)) ? 8'hFF : n_held_count[7:0];
        end else if (en_mot || en_prs) begin
            tsv = n_held_press;
        end else if (en_cur) begin
            tsv = cur_tsv;
        end else begin
            tsv = 8'd0;
        end

        n_out_item                   = '0;
        n_out_item.kickout_active    = n_tripped;
        n_out_item.kickout_reason    = n_cause;
        n_out_item.kickout_started   = started;
        n_out_item.kickout_cleared   = cleared;
        n_out_item.encoder_reset     = cleared;
        n_out_item.turn_sensor_value = tsv;
        n_out_item.frame_checksum    = tsv + FRAME_BASE;
    end

endmodule

@@ rtl/skm_checker.sv @@
// Port-level checker for the steering kickout monitor, bound to the top level.
// Depends on skm_pkg and steer_kickout_monitor_assert.svh.
`include "steer_kickout_monitor_assert.svh"

module skm_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_we,
    input logic [skm_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input logic [skm_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [skm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [skm_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import skm_pkg::*;

    t_out_item mon;
    assign mon = t_out_item'(m_axis_tdata);

    // Frame checksum always follows the reported byte
    `SKM_ASSERT_NOW(a_checksum, m_axis_tvalid, mon.frame_checksum == 8'(mon.turn_sensor_value + FRAME_BASE))

    // A reason is shown exactly while kicked out
    `SKM_ASSERT_NOW(a_reason_active, m_axis_tvalid, mon.kickout_active == (mon.kickout_reason != RSN_NONE))

    // A clear tick leaves the block idle and asks for an encoder reset
    `SKM_ASSERT_NOW(a_clear_tick, m_axis_tvalid && mon.kickout_cleared, !mon.kickout_active && mon.encoder_reset && !mon.kickout_started)

    // A stalled result holds
    `SKM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind steer_kickout_monitor skm_checker u_skm_checker (.*);
